// ===== rtl/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
// Used by every module of the block; depends on nothing.
package lr_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int ROW_SHIFT     = 10;

  localparam int COORD_W    = 9;
  localparam int ROW_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int ADDR_W     = 32;
  localparam int ERR_W      = 11;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [COORD_W-1:0] COL_MAX = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] ROW_MAX = COORD_W'(SCREEN_HEIGHT - 1);

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_FRAME_BASE = 1'b0;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    op_t                operation;
    logic [COORD_W-1:0] x_start;
    logic [ROW_W-1:0]   y_start;
    logic [COORD_W-1:0] x_end;
    logic [ROW_W-1:0]   y_end;
    logic [COLOR_W-1:0] draw_color;
  } item_t;

  typedef struct packed {
    logic               steep;
    logic [COORD_W-1:0] major_start;
    logic [COORD_W-1:0] major_end;
    logic [COORD_W-1:0] minor_start;
    logic [COORD_W-1:0] major_delta;
    logic [COORD_W-1:0] minor_delta;
    logic               minor_step_down;
  } line_setup_t;

endpackage

// ===== rtl/lr_apb.sv =====
// APB-style configuration register bank holding the frame base address.
// Depends on lr_pkg.
module lr_apb (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                           pready,
  output logic [lr_pkg::ADDR_W-1:0]      frame_base
);

  logic reg_index;

  assign reg_index = paddr[2];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
    end else if (psel && penable && pwrite && pready &&
                 reg_index == lr_pkg::REG_FRAME_BASE) begin
      frame_base <= pwdata;
    end
  end

  assign prdata = (reg_index == lr_pkg::REG_FRAME_BASE) ? frame_base : '0;

endmodule

// ===== rtl/lr_setup.sv =====
// Line setup: clamps the endpoints, picks the major axis and orders the
// endpoints along it. Pure combinational logic; depends on lr_pkg.
module lr_setup (
  input  lr_pkg::item_t       item,
  output lr_pkg::line_setup_t setup
);

  logic [lr_pkg::COORD_W-1:0] xa, xb, ya, yb;
  logic [lr_pkg::COORD_W-1:0] dx, dy;
  logic [lr_pkg::COORD_W-1:0] ma, mb, na, nb;
  logic                       steep;
  logic                       swap;

  always_comb begin
    xa = (item.x_start > lr_pkg::COL_MAX) ? lr_pkg::COL_MAX : item.x_start;
    xb = (item.x_end > lr_pkg::COL_MAX) ? lr_pkg::COL_MAX : item.x_end;
    ya = ({1'b0, item.y_start} > lr_pkg::ROW_MAX) ? lr_pkg::ROW_MAX : {1'b0, item.y_start};
    yb = ({1'b0, item.y_end} > lr_pkg::ROW_MAX) ? lr_pkg::ROW_MAX : {1'b0, item.y_end};

    dx = (xa > xb) ? xa - xb : xb - xa;
    dy = (ya > yb) ? ya - yb : yb - ya;
    steep = dy > dx;

    // Walk along the longer axis, always in the increasing direction.
    swap = steep ? (ya > yb) : (xa > xb);
    if (steep) begin
      ma = swap ? yb : ya;
      mb = swap ? ya : yb;
      na = swap ? xb : xa;
      nb = swap ? xa : xb;
    end else begin
      ma = swap ? xb : xa;
      mb = swap ? xa : xb;
      na = swap ? yb : ya;
      nb = swap ? ya : yb;
    end

    setup.steep           = steep;
    setup.major_start     = ma;
    setup.major_end       = mb;
    setup.minor_start     = na;
    setup.major_delta     = mb - ma;
    setup.minor_delta     = (na > nb) ? na - nb : nb - na;
    setup.minor_step_down = !(na < nb);
  end

endmodule

// ===== rtl/lr_stepper.sv =====
// Bresenham stepper: line state, at most one pixel per item, and the result register.
// Depends on lr_pkg.
module lr_stepper (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  lr_pkg::op_t                  operation,
  input  logic [lr_pkg::COLOR_W-1:0]   draw_color,
  input  lr_pkg::line_setup_t          setup,
  input  logic [lr_pkg::ADDR_W-1:0]    frame_base,
  output logic                         take,
  output logic                         pixel_valid,
  input  logic                         pixel_ready,
  output logic [lr_pkg::COORD_W-1:0]   pixel_x,
  output logic [lr_pkg::ROW_W-1:0]     pixel_y,
  output logic [lr_pkg::COLOR_W-1:0]   pixel_color,
  output logic [lr_pkg::ADDR_W-1:0]    pixel_address,
  output logic                         last_pixel
);

  logic                       busy;
  logic                       steep;
  logic [lr_pkg::COORD_W-1:0] major_now;
  logic [lr_pkg::COORD_W-1:0] major_end;
  logic [lr_pkg::COORD_W-1:0] minor_now;
  lr_pkg::err_t               error_acc;
  logic [lr_pkg::COORD_W-1:0] major_delta;
  logic [lr_pkg::COORD_W-1:0] minor_delta;
  logic                       minor_step_down;
  logic [lr_pkg::COLOR_W-1:0] held_color;

  // Working values for the pixel being emitted this cycle.
  logic                       cur_steep;
  logic [lr_pkg::COORD_W-1:0] cur_major;
  logic [lr_pkg::COORD_W-1:0] cur_end;
  logic [lr_pkg::COORD_W-1:0] cur_minor;
  lr_pkg::err_t               cur_err;
  logic [lr_pkg::COORD_W-1:0] cur_mdelta;
  logic [lr_pkg::COORD_W-1:0] cur_ndelta;
  logic                       cur_down;
  logic [lr_pkg::COLOR_W-1:0] cur_color;

  logic                       is_start;
  logic                       produce;
  logic                       last;
  logic [lr_pkg::COORD_W-1:0] px9;
  logic [lr_pkg::COORD_W-1:0] py9;
  logic [lr_pkg::ROW_W-1:0]   py;
  lr_pkg::err_t               err_add;
  lr_pkg::err_t               error_acc_next;
  logic [lr_pkg::COORD_W-1:0] minor_now_next;
  logic [lr_pkg::ADDR_W-1:0]  address;

  assign take     = item_valid && (!pixel_valid || pixel_ready);
  assign is_start = (operation == lr_pkg::OP_START);
  assign produce  = is_start || busy;

  always_comb begin
    if (is_start) begin
      cur_steep  = setup.steep;
      cur_major  = setup.major_start;
      cur_end    = setup.major_end;
      cur_minor  = setup.minor_start;
      cur_err    = lr_pkg::ERR_W'(0) - lr_pkg::ERR_W'(setup.major_delta >> 1);
      cur_mdelta = setup.major_delta;
      cur_ndelta = setup.minor_delta;
      cur_down   = setup.minor_step_down;
      cur_color  = draw_color;
    end else begin
      cur_steep  = steep;
      cur_major  = major_now + lr_pkg::COORD_W'(1);
      cur_end    = major_end;
      cur_minor  = minor_now;
      cur_err    = error_acc;
      cur_mdelta = major_delta;
      cur_ndelta = minor_delta;
      cur_down   = minor_step_down;
      cur_color  = held_color;
    end

    px9  = cur_steep ? cur_minor : cur_major;
    py9  = cur_steep ? cur_major : cur_minor;
    py   = py9[lr_pkg::ROW_W-1:0];
    last = (cur_major == cur_end);

    address = frame_base + (lr_pkg::ADDR_W'(py) << lr_pkg::ROW_SHIFT)
              + (lr_pkg::ADDR_W'(px9) << 1);

    // The minor axis steps only once the error turns strictly positive.
    err_add = cur_err + $signed(lr_pkg::ERR_W'(cur_ndelta));
    if (err_add > 0) begin
      minor_now_next = cur_down ? cur_minor - lr_pkg::COORD_W'(1)
                                : cur_minor + lr_pkg::COORD_W'(1);
      error_acc_next = err_add - $signed(lr_pkg::ERR_W'(cur_mdelta));
    end else begin
      minor_now_next = cur_minor;
      error_acc_next = err_add;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (take && produce) begin
        busy        <= !last;
        pixel_valid <= 1'b1;
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
    end

    if (take && produce) begin
      steep           <= cur_steep;
      major_now       <= cur_major;
      major_end       <= cur_end;
      minor_now       <= minor_now_next;
      error_acc       <= error_acc_next;
      major_delta     <= cur_mdelta;
      minor_delta     <= cur_ndelta;
      minor_step_down <= cur_down;
      held_color      <= cur_color;

      pixel_x       <= px9;
      pixel_y       <= py;
      pixel_color   <= cur_color;
      pixel_address <= address;
      last_pixel    <= last;
    end
  end

endmodule

// ===== rtl/line_rasterizer.sv =====
// Top level of the Bresenham line rasterizer: input register, setup,
// stepper and configuration port. Depends on lr_pkg, lr_apb, lr_setup, lr_stepper.
//
//  channel   handshake                  beat contents
//  item      item_valid / item_ready    operation, x_start, y_start, x_end, y_end, draw_color
//  pixel     pixel_valid / pixel_ready  pixel_x, pixel_y, pixel_color, pixel_address, last_pixel
//  config    APB psel/penable/pready    frame_base at byte address 0
//
// One item is taken every cycle while the pixel channel does not stall. An accepted
// beat sits in the input register, and its pixel then lands in the result register
// when the stepper takes it; the line state updates at that same edge.
// A tick while idle is consumed with no pixel beat.
// A stalled pixel beat holds the input register; the input register still
// takes a beat when the result register is empty or being drained.
// rst is synchronous and clears the line-active flag, both valid flags and frame_base.
module line_rasterizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          operation,
  input  logic [lr_pkg::COORD_W-1:0]    x_start,
  input  logic [lr_pkg::ROW_W-1:0]      y_start,
  input  logic [lr_pkg::COORD_W-1:0]    x_end,
  input  logic [lr_pkg::ROW_W-1:0]      y_end,
  input  logic [lr_pkg::COLOR_W-1:0]    draw_color,
  output logic                          pixel_valid,
  input  logic                          pixel_ready,
  output logic [lr_pkg::COORD_W-1:0]    pixel_x,
  output logic [lr_pkg::ROW_W-1:0]      pixel_y,
  output logic [lr_pkg::COLOR_W-1:0]    pixel_color,
  output logic [lr_pkg::ADDR_W-1:0]     pixel_address,
  output logic                          last_pixel,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lr_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);

  lr_pkg::item_t              item_q;
  logic                       item_q_valid;
  logic                       take;
  lr_pkg::line_setup_t        setup;
  logic [lr_pkg::ADDR_W-1:0]  frame_base;

  assign item_ready = !item_q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end

    if (item_valid && item_ready) begin
      item_q.operation  <= lr_pkg::op_t'(operation);
      item_q.x_start    <= x_start;
      item_q.y_start    <= y_start;
      item_q.x_end      <= x_end;
      item_q.y_end      <= y_end;
      item_q.draw_color <= draw_color;
    end
  end

  lr_apb u_apb (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .frame_base (frame_base)
  );

  lr_setup u_setup (
    .item  (item_q),
    .setup (setup)
  );

  lr_stepper u_stepper (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_q_valid),
    .operation     (item_q.operation),
    .draw_color    (item_q.draw_color),
    .setup         (setup),
    .frame_base    (frame_base),
    .take          (take),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_color   (pixel_color),
    .pixel_address (pixel_address),
    .last_pixel    (last_pixel)
  );

endmodule

// ===== dv/line_rasterizer_tb.sv =====
// Self-checking testbench for line_rasterizer: directed and random line items,
// an APB write of frame_base between phases, and a line stepper predictor.
// Depends on lr_pkg and the line_rasterizer RTL only.
`timescale 1ns / 100ps

module line_rasterizer_tb;

  typedef struct packed {
    logic [lr_pkg::COORD_W-1:0] x;
    logic [lr_pkg::ROW_W-1:0]   y;
    logic [lr_pkg::COLOR_W-1:0] color;
    logic [lr_pkg::ADDR_W-1:0]  addr;
    logic                       last;
  } pixel_beat_t;

  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          item_valid = 1'b0;
  logic                          item_ready;
  logic                          operation  = lr_pkg::OP_TICK;
  logic [lr_pkg::COORD_W-1:0]    x_start    = '0;
  logic [lr_pkg::ROW_W-1:0]      y_start    = '0;
  logic [lr_pkg::COORD_W-1:0]    x_end      = '0;
  logic [lr_pkg::ROW_W-1:0]      y_end      = '0;
  logic [lr_pkg::COLOR_W-1:0]    draw_color = '0;
  logic                          pixel_valid;
  logic                          pixel_ready = 1'b0;
  logic [lr_pkg::COORD_W-1:0]    pixel_x;
  logic [lr_pkg::ROW_W-1:0]      pixel_y;
  logic [lr_pkg::COLOR_W-1:0]    pixel_color;
  logic [lr_pkg::ADDR_W-1:0]     pixel_address;
  logic                          last_pixel;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [lr_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [lr_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [lr_pkg::APB_DATA_W-1:0] prdata;
  logic                          pready;

  lr_pkg::item_t pending_items[$];
  pixel_beat_t   expected_pixels[$];
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            hold_request  = 1'b0;
  int            hold_left     = 0;
  int            mismatches    = 0;

  // Predictor copy of the configuration and the line state.
  logic [lr_pkg::ADDR_W-1:0]  base_addr = '0;
  logic                       line_busy = 1'b0;
  logic                       line_steep = 1'b0;
  logic [lr_pkg::COORD_W-1:0] major_pos = '0;
  logic [lr_pkg::COORD_W-1:0] major_stop = '0;
  logic [lr_pkg::COORD_W-1:0] minor_pos = '0;
  int                         err_term = 0;
  logic [lr_pkg::COORD_W-1:0] span_major = '0;
  logic [lr_pkg::COORD_W-1:0] span_minor = '0;
  logic                       minor_down = 1'b0;
  logic [lr_pkg::COLOR_W-1:0] stroke_color = '0;

  line_rasterizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operation    (operation),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .draw_color   (draw_color),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .pixel_address(pixel_address),
    .last_pixel   (last_pixel),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [lr_pkg::COORD_W-1:0] clip_col(logic [lr_pkg::COORD_W-1:0] v);
    return (v > lr_pkg::COL_MAX) ? lr_pkg::COL_MAX : v;
  endfunction

  function automatic logic [lr_pkg::COORD_W-1:0] clip_row(logic [lr_pkg::ROW_W-1:0] v);
    return ({1'b0, v} > lr_pkg::ROW_MAX) ? lr_pkg::ROW_MAX : {1'b0, v};
  endfunction

  function automatic logic [lr_pkg::COORD_W-1:0] abs_diff(logic [lr_pkg::COORD_W-1:0] a,
                                                          logic [lr_pkg::COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic emit_pixel(output pixel_beat_t px);
    logic [lr_pkg::COORD_W-1:0] col;
    logic [lr_pkg::COORD_W-1:0] row;
    col = line_steep ? minor_pos : major_pos;
    row = line_steep ? major_pos : minor_pos;
    px.x     = col;
    px.y     = row[lr_pkg::ROW_W-1:0];
    px.color = stroke_color;
    px.addr  = base_addr + (lr_pkg::ADDR_W'(px.y) << lr_pkg::ROW_SHIFT)
               + (lr_pkg::ADDR_W'(px.x) << 1);
    px.last  = (major_pos == major_stop);
    if (px.last) begin
      line_busy = 1'b0;
    end else begin
      line_busy = 1'b1;
      err_term += int'(span_minor);
      // The minor axis moves only once the error is strictly positive.
      if (err_term > 0) begin
        minor_pos = minor_down ? minor_pos - lr_pkg::COORD_W'(1)
                               : minor_pos + lr_pkg::COORD_W'(1);
        err_term -= int'(span_major);
      end
    end
  endtask

  task automatic predict_pixel(input lr_pkg::item_t it, output bit produced,
                               output pixel_beat_t px);
    logic [lr_pkg::COORD_W-1:0] xa, ya, xb, yb, ma, mb, na, nb, t;
    produced = 1'b0;
    px = '0;
    if (it.operation == lr_pkg::OP_START) begin
      xa = clip_col(it.x_start);
      ya = clip_row(it.y_start);
      xb = clip_col(it.x_end);
      yb = clip_row(it.y_end);
      line_steep = abs_diff(ya, yb) > abs_diff(xa, xb);
      if (line_steep) begin
        ma = ya; mb = yb; na = xa; nb = xb;
      end else begin
        ma = xa; mb = xb; na = ya; nb = yb;
      end
      if (ma > mb) begin
        t = ma; ma = mb; mb = t;
        t = na; na = nb; nb = t;
      end
      span_major   = mb - ma;
      span_minor   = abs_diff(na, nb);
      minor_down   = !(na < nb);
      major_pos    = ma;
      major_stop   = mb;
      minor_pos    = na;
      err_term     = -int'(span_major / 2);
      stroke_color = it.draw_color;
      emit_pixel(px);
      produced = 1'b1;
    end else if (line_busy) begin
      major_pos = major_pos + lr_pkg::COORD_W'(1);
      emit_pixel(px);
      produced = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic lr_pkg::item_t make_item(lr_pkg::op_t op, int xa, int ya, int xb,
                                              int yb, int color);
    lr_pkg::item_t it;
    it.operation  = op;
    it.x_start    = lr_pkg::COORD_W'(xa);
    it.y_start    = lr_pkg::ROW_W'(ya);
    it.x_end      = lr_pkg::COORD_W'(xb);
    it.y_end      = lr_pkg::ROW_W'(yb);
    it.draw_color = lr_pkg::COLOR_W'(color);
    return it;
  endfunction

  // Tick payloads are don't-care, so they carry random bits.
  task automatic queue_ticks(int count);
    repeat (count) begin
      pending_items.push_back(make_item(lr_pkg::OP_TICK, $urandom_range(511),
                                        $urandom_range(255), $urandom_range(511),
                                        $urandom_range(255), $urandom_range(65535)));
    end
  endtask

  task automatic queue_line(int xa, int ya, int xb, int yb, int color, int ticks);
    pending_items.push_back(make_item(lr_pkg::OP_START, xa, ya, xb, yb, color));
    queue_ticks(ticks);
  endtask

  function automatic int line_length(int xa, int ya, int xb, int yb);
    int dx, dy;
    dx = ((xa > 319) ? 319 : xa) - ((xb > 319) ? 319 : xb);
    dy = ((ya > 239) ? 239 : ya) - ((yb > 239) ? 239 : yb);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx > dy) ? dx : dy;
  endfunction

  function automatic int bound(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  task automatic queue_random_line();
    int xa, ya, xb, yb, span, ticks, pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      queue_ticks(1);
    end else begin
      if (pick < 10) begin
        // Full-range endpoints, off-screen values included.
        xa = $urandom_range(511);
        ya = $urandom_range(255);
        xb = $urandom_range(511);
        yb = $urandom_range(255);
      end else begin
        xa = $urandom_range(319);
        ya = $urandom_range(239);
        xb = bound(xa + int'($urandom_range(24)) - 12, 511);
        yb = bound(ya + int'($urandom_range(24)) - 12, 255);
      end
      span = line_length(xa, ya, xb, yb);
      pick = $urandom_range(99);
      if (pick < 70 || span == 0)
        ticks = span;
      else if (pick < 85)
        ticks = $urandom_range(span - 1);
      else
        ticks = span + $urandom_range(1, 2);
      queue_line(xa, ya, xb, yb, $urandom_range(65535), ticks);
    end
  endtask

  task automatic write_frame_base(logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lr_pkg::REG_FRAME_BASE, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    base_addr = value;
  endtask

  // Waits until every queued item is taken and every pixel has come back,
  // then lets the input and result registers empty out behind any idle tick.
  task automatic wait_drained();
    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random(int count, bit with_hold);
    while (pending_items.size() < count) queue_random_line();
    if (with_hold) begin
      while (pending_items.size() > count / 2) @(posedge clk);
      hold_request = 1'b1;
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 55;
    write_frame_base(32'hFFFF_FFFF);
    queue_ticks(1);                                  // tick with no line active
    queue_line(0, 0, 0, 0, 16'h0000, 1);             // single point, then idle tick
    queue_line(511, 255, 0, 0, 16'hFFFF, 2);         // clamped ends, abandoned early
    queue_line(5, 7, 0, 7, 16'hA5A5, 6);             // horizontal, reversed, extra tick
    queue_line(10, 200, 10, 196, 16'h5A5A, 4);       // vertical
    queue_line(300, 0, 298, 5, 16'h1234, 5);         // steep, minor steps down
    queue_line(0, 0, 4, 2, 16'h8001, 4);             // error ties
    queue_line(320, 240, 511, 255, 16'h7FFE, 0);     // both ends clamp to one corner
    wait_drained();

    write_frame_base($urandom);
    run_random(600, 1'b1);

    send_idle_pct = 55;
    recv_idle_pct = 21;
    write_frame_base(32'h0000_0000);
    run_random(600, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_frame_base(32'h8000_03FF);
    run_random(500, 1'b1);

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive_items
    lr_pkg::item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        item_valid <= 1'b1;
        operation  <= nxt.operation;
        x_start    <= nxt.x_start;
        y_start    <= nxt.y_start;
        x_end      <= nxt.x_end;
        y_end      <= nxt.y_end;
        draw_color <= nxt.draw_color;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // The long hold-off backs the block up until it stops taking items.
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      pixel_ready <= 1'b0;
      hold_left   <= 0;
    end else if (hold_left != 0) begin
      pixel_ready <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_request) begin
      pixel_ready  <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_request <= 1'b0;
    end else begin
      pixel_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_beats
    lr_pkg::item_t taken;
    pixel_beat_t   want;
    bit            made;
    if (!rst) begin
      if (pixel_valid && pixel_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 100)
            $display("%0t: pixel beat expected none actual x=%0d y=%0d", $time,
                     pixel_x, pixel_y);
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", 32'(want.x), 32'(pixel_x));
          check_field("pixel_y", 32'(want.y), 32'(pixel_y));
          check_field("pixel_color", 32'(want.color), 32'(pixel_color));
          check_field("pixel_address", want.addr, pixel_address);
          check_field("last_pixel", 32'(want.last), 32'(last_pixel));
        end
      end
      if (item_valid && item_ready) begin
        taken.operation  = lr_pkg::op_t'(operation);
        taken.x_start    = x_start;
        taken.y_start    = y_start;
        taken.x_end      = x_end;
        taken.y_end      = y_end;
        taken.draw_color = draw_color;
        predict_pixel(taken, made, want);
        if (made) expected_pixels.push_back(want);
      end
    end
  end

endmodule
